>>> rtl/core/force_feedback_safety_gate_top_macros.svh
// Assertion macros for the safety gate RTL, used by ffsg_back.
// FFSG_ASSERT checks a property on the rising edge of clk, off while rst is high.
// FFSG_ASSERT_IMP checks that ante implies cons in the same cycle.
`ifndef FORCE_FEEDBACK_SAFETY_GATE_TOP_MACROS_SVH
`define FORCE_FEEDBACK_SAFETY_GATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FFSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFSG_ASSERT_IMP(lbl, ante, cons, msg) \
  `FFSG_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define FFSG_ASSERT(lbl, prop, msg)
`define FFSG_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/ffsg_pkg.sv
`default_nettype none
package ffsg_pkg;

  localparam int TW = 40;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam int MAX_WATCHDOG_US_DEF = 100000;
  localparam int MAX_TORQUE_DEF = 32767;
  localparam int MIN_SLEW_DEF = 1;
  localparam int MAX_SLEW_DEF = 65535;

  localparam logic signed [15:0] ZERO_BAND = 16'sd3;

  localparam logic        PROFILE_ENABLED_RST = 1'b0;
  localparam logic [14:0] TORQUE_CEILING_RST = 15'd32767;
  localparam logic [14:0] MASTER_GAIN_RST = 15'd32767;
  localparam logic [15:0] SLEW_RATE_RST = 16'd1024;
  localparam logic [23:0] WATCHDOG_TIMEOUT_RST = 24'd100000;

  typedef enum logic [2:0] {
    K_UPDATE,
    K_TICK,
    K_ENABLE,
    K_DISABLE,
    K_ESTOP,
    K_BACKEND_FAIL,
    K_DEV_UNAVAIL,
    K_CLEAR_FAULT
  } kind_t;

  typedef enum logic [2:0] {
    M_DISABLED,
    M_ARMED,
    M_ACTIVE,
    M_STOPPING,
    M_FAULTED
  } mode_t;

  typedef enum logic [2:0] {
    REG_PROFILE_ENABLED,
    REG_TORQUE_CEILING,
    REG_MASTER_GAIN,
    REG_SLEW_RATE,
    REG_WATCHDOG_TIMEOUT
  } cfg_reg_t;

  typedef struct packed {
    kind_t                kind;
    logic signed [15:0]   req_constant_force;
    logic signed [15:0]   req_spring;
    logic signed [15:0]   req_damper;
    logic signed [15:0]   req_gain;
    logic [TW-1:0]        telemetry_time;
    logic [TW-1:0]        now_time;
  } in_t;

  typedef struct packed {
    logic                 apply_command;
    logic                 stop_device;
    logic signed [15:0]   out_constant_force;
    logic [14:0]          out_spring;
    logic [14:0]          out_damper;
    logic [14:0]          out_gain;
    mode_t                mode_now;
  } out_t;

  typedef struct packed {
    logic        profile_enabled;
    logic [14:0] torque_ceiling;
    logic [14:0] master_gain;
    logic [15:0] slew_rate;
    logic [23:0] watchdog_timeout;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic             tele_fresh;
    logic             enable_ok;
    logic [TW-1:0]    now_time;
    logic [TW-1:0]    tele_time;
    logic [3:0][15:0] tgt;
  } cmd_t;

  function automatic logic [23:0] wd_limit(input logic [23:0] timeout, input logic [23:0] cap);
    return (timeout > cap) ? cap : timeout;
  endfunction

  function automatic logic all_zero(input logic [3:0][15:0] f);
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic signed [15:0] d;
    c = $signed(f[0]);
    s = $signed(f[1]);
    d = $signed(f[2]);
    return (c >= -ZERO_BAND) && (c <= ZERO_BAND) && (s <= ZERO_BAND) && (d <= ZERO_BAND);
  endfunction

  function automatic logic [15:0] slew_one(input logic [15:0] cur, input logic [15:0] want,
                                           input logic [15:0] step);
    logic signed [17:0] c;
    logic signed [17:0] w;
    logic signed [17:0] d;
    logic [17:0]        mag;
    logic signed [17:0] r;
    c = $signed({{2{cur[15]}}, cur});
    w = $signed({{2{want[15]}}, want});
    d = w - c;
    mag = d[17] ? 18'(-d) : 18'(d);
    if (mag <= {2'b00, step}) begin
      r = w;
    end else if (d[17]) begin
      r = c - $signed({2'b00, step});
    end else begin
      r = c + $signed({2'b00, step});
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/ffsg_front.sv
`default_nettype none
module ffsg_front #(
  parameter int MAX_TORQUE = ffsg_pkg::MAX_TORQUE_DEF,
  parameter int MAX_WATCHDOG_US = ffsg_pkg::MAX_WATCHDOG_US_DEF
) (
  input  ffsg_pkg::cfg_t cfg,
  input  ffsg_pkg::in_t  req,
  output ffsg_pkg::cmd_t cmd
);

  localparam logic [14:0] TORQ_CAP = 15'(MAX_TORQUE);
  localparam logic [23:0] WD_CAP = 24'(MAX_WATCHDOG_US);

  logic [14:0]        ceil;
  logic signed [16:0] ceil_s;
  logic signed [16:0] mg_s;
  logic signed [16:0] cf_raw, sp_raw, dm_raw, gn_raw;
  logic signed [16:0] cf, sp, dm, gn;
  logic               kill;
  logic [23:0]        wd;
  logic [ffsg_pkg::TW-1:0] age;

  always_comb begin
    ceil = (cfg.torque_ceiling > TORQ_CAP) ? TORQ_CAP : cfg.torque_ceiling;
    ceil_s = $signed({2'b00, ceil});
    mg_s = $signed({2'b00, cfg.master_gain});

    cf_raw = $signed({req.req_constant_force[15], req.req_constant_force});
    sp_raw = $signed({req.req_spring[15], req.req_spring});
    dm_raw = $signed({req.req_damper[15], req.req_damper});
    gn_raw = $signed({req.req_gain[15], req.req_gain});

    if (cf_raw > ceil_s) begin
      cf = ceil_s;
    end else if (cf_raw < -ceil_s) begin
      cf = -ceil_s;
    end else begin
      cf = cf_raw;
    end

    if (sp_raw < 17'sd0) begin
      sp = 17'sd0;
    end else if (sp_raw > ceil_s) begin
      sp = ceil_s;
    end else begin
      sp = sp_raw;
    end

    if (dm_raw < 17'sd0) begin
      dm = 17'sd0;
    end else if (dm_raw > ceil_s) begin
      dm = ceil_s;
    end else begin
      dm = dm_raw;
    end

    if (gn_raw < 17'sd0) begin
      gn = 17'sd0;
    end else if (gn_raw > mg_s) begin
      gn = mg_s;
    end else begin
      gn = gn_raw;
    end

    kill = !cfg.profile_enabled || ($signed(gn[15:0]) <= ffsg_pkg::ZERO_BAND);

    wd = ffsg_pkg::wd_limit(cfg.watchdog_timeout, WD_CAP);
    age = req.now_time - req.telemetry_time;

    cmd.kind = req.kind;
    cmd.enable_ok = cfg.profile_enabled;
    cmd.now_time = req.now_time;
    cmd.tele_time = req.telemetry_time;
    cmd.tele_fresh = (req.now_time >= req.telemetry_time) &&
                     (age <= {{(ffsg_pkg::TW - 24){1'b0}}, wd});
    cmd.tgt[0] = kill ? 16'd0 : cf[15:0];
    cmd.tgt[1] = kill ? 16'd0 : sp[15:0];
    cmd.tgt[2] = kill ? 16'd0 : dm[15:0];
    cmd.tgt[3] = kill ? 16'd0 : gn[15:0];
  end

endmodule
`default_nettype wire

>>> rtl/core/ffsg_queue.sv
`default_nettype none
module ffsg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ffsg_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output ffsg_pkg::cmd_t rdata,
  output logic           avail
);

  localparam int D = ffsg_pkg::QUEUE_DEPTH;
  localparam int AW = ffsg_pkg::QUEUE_AW;
  localparam int CW = $clog2(D + 1);

  ffsg_pkg::cmd_t slots [D];
  logic [AW-1:0]  wp, rp;
  logic [CW-1:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(D - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(D - 1)) ? '0 : rp + AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wdata;
    end
  end

  assign full = (cnt == CW'(D));
  assign avail = (cnt != '0);
  assign rdata = slots[rp];

endmodule
`default_nettype wire

>>> rtl/core/ffsg_back.sv
`default_nettype none
`include "force_feedback_safety_gate_top_macros.svh"
module ffsg_back #(
  parameter int MAX_WATCHDOG_US = ffsg_pkg::MAX_WATCHDOG_US_DEF,
  parameter int MIN_SLEW = ffsg_pkg::MIN_SLEW_DEF,
  parameter int MAX_SLEW = ffsg_pkg::MAX_SLEW_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ffsg_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  ffsg_pkg::cmd_t q_data,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ffsg_pkg::out_t rsp
);

  localparam int TW = ffsg_pkg::TW;
  localparam logic [23:0] WD_CAP = 24'(MAX_WATCHDOG_US);
  localparam logic [15:0] SLEW_LO = 16'(MIN_SLEW);
  localparam logic [15:0] SLEW_HI = 16'(MAX_SLEW);

  ffsg_pkg::mode_t  mode, mode_next;
  ffsg_pkg::mode_t  idle_target, idle_target_next;
  logic             stop_pending, stop_pending_next;
  logic [3:0][15:0] applied, applied_next;
  logic             app_valid, app_valid_next;
  logic [TW-1:0]    app_stamp, app_stamp_next;
  logic             tele_valid, tele_valid_next;
  logic [TW-1:0]    tele_stamp, tele_stamp_next;
  logic             upd_valid, upd_valid_next;
  logic [TW-1:0]    upd_stamp, upd_stamp_next;

  logic [TW-1:0]    now;
  logic [15:0]      rate_lo, rate;
  logic [TW-1:0]    dt;
  logic [41:0]      prod;
  logic [15:0]      step;
  logic [23:0]      wd;
  logic             committed, tele_stale, upd_stale, cur_zero;
  logic             settle_go, tick_path, mark_active;
  logic [3:0][15:0] tgt, sf;
  logic             sf_zero;
  logic             apply_now, stop_now;
  logic [3:0][15:0] f;
  ffsg_pkg::out_t   rsp_next;

  assign pop = q_valid && (!rsp_valid || rsp_ready);
  assign now = q_data.now_time;

  always_comb begin
    rate_lo = (cfg.slew_rate < SLEW_LO) ? SLEW_LO : cfg.slew_rate;
    rate = (rate_lo > SLEW_HI) ? SLEW_HI : rate_lo;
    dt = (app_valid && now > app_stamp) ? now - app_stamp : '0;
    prod = {26'd0, rate} * {16'd0, dt[25:0]};
    if (dt[TW-1:26] != '0) begin
      step = (rate != 16'd0) ? 16'hFFFF : 16'd0;
    end else if (prod[41:26] != 16'd0) begin
      step = 16'hFFFF;
    end else begin
      step = prod[25:10];
    end

    wd = ffsg_pkg::wd_limit(cfg.watchdog_timeout, WD_CAP);
    committed = mode inside {ffsg_pkg::M_DISABLED, ffsg_pkg::M_FAULTED, ffsg_pkg::M_STOPPING};
    tele_stale = !tele_valid || (now < tele_stamp) ||
                 ((now - tele_stamp) > {{(TW - 24){1'b0}}, wd});
    upd_stale = (q_data.kind != ffsg_pkg::K_UPDATE) &&
                (!upd_valid || (now < upd_stamp) ||
                 ((now - upd_stamp) > {{(TW - 24){1'b0}}, wd}));
    cur_zero = ffsg_pkg::all_zero(applied);

    mode_next = mode;
    idle_target_next = idle_target;
    stop_pending_next = stop_pending;
    applied_next = applied;
    app_valid_next = app_valid;
    app_stamp_next = app_stamp;
    tele_valid_next = tele_valid;
    tele_stamp_next = tele_stamp;
    upd_valid_next = upd_valid;
    upd_stamp_next = upd_stamp;
    settle_go = 1'b0;
    tick_path = 1'b0;
    mark_active = 1'b0;
    tgt = '0;
    apply_now = 1'b0;
    stop_now = 1'b0;
    f = '0;

    case (q_data.kind)
      ffsg_pkg::K_UPDATE: begin
        upd_valid_next = 1'b1;
        upd_stamp_next = now;
        if (committed) begin
          settle_go = 1'b1;
        end else if (!q_data.tele_fresh) begin
          tick_path = 1'b1;
        end else begin
          tele_valid_next = 1'b1;
          tele_stamp_next = q_data.tele_time;
          tgt = q_data.tgt;
          settle_go = 1'b1;
          mark_active = 1'b1;
        end
      end
      ffsg_pkg::K_TICK: begin
        tick_path = 1'b1;
      end
      ffsg_pkg::K_ENABLE: begin
        if (mode == ffsg_pkg::M_DISABLED && q_data.enable_ok) begin
          mode_next = ffsg_pkg::M_ARMED;
          idle_target_next = ffsg_pkg::M_ARMED;
        end
      end
      ffsg_pkg::K_DISABLE: begin
        if (mode != ffsg_pkg::M_DISABLED && mode != ffsg_pkg::M_FAULTED) begin
          stop_pending_next = 1'b1;
          idle_target_next = ffsg_pkg::M_DISABLED;
          mode_next = ffsg_pkg::M_STOPPING;
        end
      end
      ffsg_pkg::K_ESTOP: begin
        applied_next = '0;
        app_valid_next = 1'b0;
        app_stamp_next = '0;
        stop_pending_next = 1'b1;
        idle_target_next = ffsg_pkg::M_DISABLED;
        mode_next = ffsg_pkg::M_DISABLED;
      end
      ffsg_pkg::K_BACKEND_FAIL: begin
        applied_next = '0;
        app_valid_next = 1'b0;
        app_stamp_next = '0;
        stop_pending_next = 1'b1;
        idle_target_next = ffsg_pkg::M_FAULTED;
        mode_next = ffsg_pkg::M_FAULTED;
      end
      ffsg_pkg::K_DEV_UNAVAIL: begin
        if (mode != ffsg_pkg::M_DISABLED && mode != ffsg_pkg::M_FAULTED) begin
          applied_next = '0;
          app_valid_next = 1'b0;
          app_stamp_next = '0;
          stop_pending_next = 1'b1;
          idle_target_next = ffsg_pkg::M_ARMED;
          mode_next = ffsg_pkg::M_STOPPING;
        end
      end
      ffsg_pkg::K_CLEAR_FAULT: begin
        if (mode == ffsg_pkg::M_FAULTED) begin
          stop_pending_next = 1'b0;
          idle_target_next = ffsg_pkg::M_DISABLED;
          mode_next = ffsg_pkg::M_DISABLED;
        end
      end
      default: begin
      end
    endcase

    if (tick_path) begin
      if (committed) begin
        settle_go = 1'b1;
      end else if ((tele_stale || upd_stale) && !cur_zero) begin
        stop_pending_next = 1'b1;
        idle_target_next = ffsg_pkg::M_ARMED;
        mode_next = ffsg_pkg::M_STOPPING;
        settle_go = 1'b1;
      end
    end

    for (int i = 0; i < 4; i++) begin
      sf[i] = ffsg_pkg::slew_one(applied[i], tgt[i], step);
    end
    sf_zero = ffsg_pkg::all_zero(sf);

    if (settle_go) begin
      applied_next = sf;
      app_valid_next = 1'b1;
      app_stamp_next = now;
      if (!sf_zero) begin
        apply_now = 1'b1;
        f = sf;
        if (mark_active) begin
          mode_next = ffsg_pkg::M_ACTIVE;
        end
      end else if (stop_pending_next) begin
        apply_now = 1'b1;
        stop_now = 1'b1;
        f = sf;
        stop_pending_next = 1'b0;
        mode_next = idle_target_next;
      end
    end

    rsp_next.apply_command = apply_now;
    rsp_next.stop_device = stop_now;
    rsp_next.out_constant_force = $signed(f[0]);
    rsp_next.out_spring = f[1][14:0];
    rsp_next.out_damper = f[2][14:0];
    rsp_next.out_gain = f[3][14:0];
    rsp_next.mode_now = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ffsg_pkg::M_DISABLED;
      idle_target <= ffsg_pkg::M_DISABLED;
      stop_pending <= 1'b0;
      applied <= '0;
      app_valid <= 1'b0;
      tele_valid <= 1'b0;
      upd_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        mode <= mode_next;
        idle_target <= idle_target_next;
        stop_pending <= stop_pending_next;
        applied <= applied_next;
        app_valid <= app_valid_next;
        tele_valid <= tele_valid_next;
        upd_valid <= upd_valid_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      app_stamp <= app_stamp_next;
      tele_stamp <= tele_stamp_next;
      upd_stamp <= upd_stamp_next;
      rsp <= rsp_next;
    end
  end

  `FFSG_ASSERT_IMP(a_stop_leaves_stopping, rsp_valid && rsp.stop_device, rsp.mode_now != ffsg_pkg::M_STOPPING, "stop edge left mode in stopping")
  `FFSG_ASSERT(a_stop_clears_pending, pop && stop_now |=> !stop_pending, "stop edge kept stop pending")
  `FFSG_ASSERT_IMP(a_invalid_stamp_zero, !app_valid, applied == '0, "forces held without a stamp")
  `FFSG_ASSERT_IMP(a_idle_fields_zero, rsp_valid && !rsp.apply_command, rsp.out_constant_force == 16'sd0 && rsp.out_spring == 15'd0 && rsp.out_damper == 15'd0 && rsp.out_gain == 15'd0, "force fields set without a command")

endmodule
`default_nettype wire

>>> rtl/core/force_feedback_safety_gate_top.sv
// Channel   Handshake              Payload           Width
// req       req_valid/req_ready    ffsg_pkg::in_t    event and requested forces
// rsp       rsp_valid/rsp_ready    ffsg_pkg::out_t   command, stop edge, mode
// cfg       cfg_we                 cfg_index/data    register write, no read-back
//
// One event per cycle while rsp_ready is high; results pass a queue slot, then the rsp register.
// The rate is set by the back end's state loop (slew step, force slew, mode), all combinational.
// Synchronous reset clears mode, stop state, forces and stamp valid bits at once.
// A two-entry queue sits between classification and the state loop; req_ready drops when it fills.
// A stalled rsp holds its register while the queue takes events until it fills.
`default_nettype none
module force_feedback_safety_gate_top #(
  parameter int MAX_WATCHDOG_US = ffsg_pkg::MAX_WATCHDOG_US_DEF,
  parameter int MAX_TORQUE = ffsg_pkg::MAX_TORQUE_DEF,
  parameter int MIN_SLEW = ffsg_pkg::MIN_SLEW_DEF,
  parameter int MAX_SLEW = ffsg_pkg::MAX_SLEW_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ffsg_pkg::in_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ffsg_pkg::out_t rsp,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [23:0]    cfg_data
);

  ffsg_pkg::cfg_t cfg;
  ffsg_pkg::cmd_t front_cmd;
  ffsg_pkg::cmd_t q_data;
  logic           q_full, q_avail, q_pop, q_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.profile_enabled <= ffsg_pkg::PROFILE_ENABLED_RST;
      cfg.torque_ceiling <= ffsg_pkg::TORQUE_CEILING_RST;
      cfg.master_gain <= ffsg_pkg::MASTER_GAIN_RST;
      cfg.slew_rate <= ffsg_pkg::SLEW_RATE_RST;
      cfg.watchdog_timeout <= ffsg_pkg::WATCHDOG_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ffsg_pkg::REG_PROFILE_ENABLED:  cfg.profile_enabled <= cfg_data[0];
        ffsg_pkg::REG_TORQUE_CEILING:   cfg.torque_ceiling <= cfg_data[14:0];
        ffsg_pkg::REG_MASTER_GAIN:      cfg.master_gain <= cfg_data[14:0];
        ffsg_pkg::REG_SLEW_RATE:        cfg.slew_rate <= cfg_data[15:0];
        ffsg_pkg::REG_WATCHDOG_TIMEOUT: cfg.watchdog_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign req_ready = !q_full;
  assign q_push = req_valid && req_ready;

  ffsg_front #(
    .MAX_TORQUE      (MAX_TORQUE),
    .MAX_WATCHDOG_US (MAX_WATCHDOG_US)
  ) u_front (
    .cfg (cfg),
    .req (req),
    .cmd (front_cmd)
  );

  ffsg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .avail (q_avail)
  );

  ffsg_back #(
    .MAX_WATCHDOG_US (MAX_WATCHDOG_US),
    .MIN_SLEW        (MIN_SLEW),
    .MAX_SLEW        (MAX_SLEW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_avail),
    .q_data    (q_data),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
